// File: rtl/core/hsvrgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
// No dependencies; imported by every module of the converter.
`default_nettype none

package hsvrgb_pkg;

   localparam int COMPONENT_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT    = 4;

   localparam int SECTOR_BITS = 3;

   localparam logic [SECTOR_BITS-1:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [SECTOR_BITS-1:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [SECTOR_BITS-1:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [SECTOR_BITS-1:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [SECTOR_BITS-1:0] SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam logic [SECTOR_BITS-1:0] SECTOR_MAGENTA_RED   = 3'd5;

   typedef struct packed {
      logic full;
      logic empty;
   } hsvrgb_queue_status_type;

endpackage

`default_nettype wire

// File: rtl/core/hsvrgb_front.sv
// Front end: takes HSV transfers, splits hue into sector and fraction.
// Depends on hsvrgb_pkg; feeds hsvrgb_queue.
`default_nettype none

module hsvrgb_front #(
   parameter int COMPONENT_BITS = hsvrgb_pkg::COMPONENT_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [COMPONENT_BITS-1:0]             req_hue,
   input  wire logic [COMPONENT_BITS-1:0]             req_saturation,
   input  wire logic [COMPONENT_BITS-1:0]             req_brightness,
   input  wire hsvrgb_pkg::hsvrgb_queue_status_type   queue_status,
   output logic                                       push,
   output logic [hsvrgb_pkg::SECTOR_BITS-1:0]         push_sector,
   output logic [COMPONENT_BITS-1:0]                  push_frac,
   output logic [COMPONENT_BITS-1:0]                  push_sat,
   output logic [COMPONENT_BITS-1:0]                  push_val
);
   import hsvrgb_pkg::*;

   localparam int W = COMPONENT_BITS;

   logic                   valid_ff, valid_in;
   logic [SECTOR_BITS-1:0] sector_ff;
   logic [W-1:0]           frac_ff, sat_ff, val_ff;
   logic [W+2:0]           hue6;
   logic                   take;

   assign push      = valid_ff && !queue_status.full;
   assign req_stall = valid_ff && queue_status.full;
   assign take      = req_valid && !req_stall;

   // hue * 6 as two shifted adds
   assign hue6 = {1'b0, req_hue, 2'b00} + {2'b00, req_hue, 1'b0};

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sector_ff <= hue6[W+2:W];
         frac_ff   <= hue6[W-1:0];
         sat_ff    <= req_saturation;
         val_ff    <= req_brightness;
      end
   end

   assign push_sector = sector_ff;
   assign push_frac   = frac_ff;
   assign push_sat    = sat_ff;
   assign push_val    = val_ff;

endmodule

`default_nettype wire

// File: rtl/core/hsvrgb_queue.sv
// Short FIFO between front end and arithmetic back end.
// Depends on hsvrgb_pkg for the status struct.
`default_nettype none

module hsvrgb_queue #(
   parameter int DATA_BITS = 51,
   parameter int DEPTH     = hsvrgb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   input  wire logic [DATA_BITS-1:0]                push_data,
   input  wire logic                                pop,
   output logic [DATA_BITS-1:0]                     head_data,
   output hsvrgb_pkg::hsvrgb_queue_status_type      status
);
   import hsvrgb_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0]  queue_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] ptr);
      if (ptr == PTR_BITS'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_BITS'(1);
   endfunction

   assign status.full  = (count_ff == COUNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_data    = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
      end
      if (pop) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hsvrgb_back.sv
// Back end: p/q/t products, division by full scale, sector routing.
// Depends on hsvrgb_pkg; drains hsvrgb_queue and drives the rsp_ channel.
`default_nettype none

module hsvrgb_back #(
   parameter int COMPONENT_BITS = hsvrgb_pkg::COMPONENT_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire hsvrgb_pkg::hsvrgb_queue_status_type   queue_status,
   output logic                                       pop,
   input  wire logic [hsvrgb_pkg::SECTOR_BITS-1:0]    head_sector,
   input  wire logic [COMPONENT_BITS-1:0]             head_frac,
   input  wire logic [COMPONENT_BITS-1:0]             head_sat,
   input  wire logic [COMPONENT_BITS-1:0]             head_val,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [COMPONENT_BITS-1:0]                  rsp_red,
   output logic [COMPONENT_BITS-1:0]                  rsp_green,
   output logic [COMPONENT_BITS-1:0]                  rsp_blue
);
   import hsvrgb_pkg::*;

   localparam int W = COMPONENT_BITS;
   localparam logic [W-1:0] FULL = {W{1'b1}};
   localparam logic [W:0]   TURN = {1'b1, {W{1'b0}}};

   // x / (2^W - 1) for x <= (2^W - 1)^2: x = a*2^W + b gives a + ((a + b) >= M)
   function automatic logic [W-1:0] div_full(input logic [2*W-1:0] x);
      logic [W:0] sum;
      sum = {1'b0, x[2*W-1:W]} + {1'b0, x[W-1:0]};
      return x[2*W-1:W] + W'(sum >= {1'b0, FULL});
   endfunction

   logic                   advance;

   logic                   s1_valid_ff;
   logic [SECTOR_BITS-1:0] s1_sector_ff;
   logic [W-1:0]           s1_val_ff, s1_kq_ff, s1_kt_ff;
   logic [2*W-1:0]         s1_prod_p_ff;
   logic [2*W-1:0]         prod_kq;
   logic [2*W:0]           prod_kt;

   logic                   s2_valid_ff;
   logic [SECTOR_BITS-1:0] s2_sector_ff;
   logic [W-1:0]           s2_val_ff, s2_p_ff;
   logic [2*W-1:0]         s2_prod_q_ff, s2_prod_t_ff;

   logic                   out_valid_ff;
   logic [W-1:0]           red_ff, green_ff, blue_ff;
   logic [W-1:0]           red_in, green_in, blue_in;
   logic [W-1:0]           q_val, t_val;

   assign advance = !out_valid_ff || !rsp_stall;
   assign pop     = advance && !queue_status.empty;

   assign prod_kq = head_frac * head_sat;
   assign prod_kt = (TURN - {1'b0, head_frac}) * head_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sector_ff <= head_sector;
         s1_val_ff    <= head_val;
         s1_prod_p_ff <= head_val * (FULL - head_sat);
         s1_kq_ff     <= prod_kq[2*W-1:W];
         s1_kt_ff     <= prod_kt[2*W-1:W];

         s2_sector_ff <= s1_sector_ff;
         s2_val_ff    <= s1_val_ff;
         s2_p_ff      <= div_full(s1_prod_p_ff);
         s2_prod_q_ff <= s1_val_ff * (FULL - s1_kq_ff);
         s2_prod_t_ff <= s1_val_ff * (FULL - s1_kt_ff);

         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
      end
   end

   assign q_val = div_full(s2_prod_q_ff);
   assign t_val = div_full(s2_prod_t_ff);

   always_comb begin
      unique case (s2_sector_ff)
         SECTOR_RED_YELLOW: begin
            red_in = s2_val_ff; green_in = t_val;     blue_in = s2_p_ff;
         end
         SECTOR_YELLOW_GREEN: begin
            red_in = q_val;     green_in = s2_val_ff; blue_in = s2_p_ff;
         end
         SECTOR_GREEN_CYAN: begin
            red_in = s2_p_ff;   green_in = s2_val_ff; blue_in = t_val;
         end
         SECTOR_CYAN_BLUE: begin
            red_in = s2_p_ff;   green_in = q_val;     blue_in = s2_val_ff;
         end
         SECTOR_BLUE_MAGENTA: begin
            red_in = t_val;     green_in = s2_p_ff;   blue_in = s2_val_ff;
         end
         default: begin
            red_in = s2_val_ff; green_in = s2_p_ff;   blue_in = q_val;
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

`default_nettype wire

// File: rtl/core/hsv_to_rgb_converter_core.sv
// Channel  Ports                                       Direction
// req      req_valid req_stall req_hue/saturation/brightness  HSV in
// rsp      rsp_valid rsp_stall rsp_red/green/blue             RGB out
//
// One transfer per cycle on both sides while no stall holds the flow. A req transfer
// loads the front register, then the queue slot; two multiplier stages and the
// divide-by-full-scale output register follow; rsp_valid comes from that register.
// Reset clears valid flags and queue pointers; payload registers are not reset.
// rsp_stall freezes the back end while rsp_valid is high; the queue then fills to
// QUEUE_DEPTH items and req_stall rises once the front register also holds one.
// Top level: instantiates hsvrgb_front, hsvrgb_queue and hsvrgb_back; uses hsvrgb_pkg.
`default_nettype none

module hsv_to_rgb_converter_core #(
   parameter int COMPONENT_BITS = hsvrgb_pkg::COMPONENT_BITS_DEFAULT,
   parameter int QUEUE_DEPTH    = hsvrgb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [COMPONENT_BITS-1:0] req_hue,
   input  wire logic [COMPONENT_BITS-1:0] req_saturation,
   input  wire logic [COMPONENT_BITS-1:0] req_brightness,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [COMPONENT_BITS-1:0]      rsp_red,
   output logic [COMPONENT_BITS-1:0]      rsp_green,
   output logic [COMPONENT_BITS-1:0]      rsp_blue
);
   import hsvrgb_pkg::*;

   localparam int W         = COMPONENT_BITS;
   localparam int DATA_BITS = SECTOR_BITS + 3 * W;

   hsvrgb_queue_status_type queue_status;
   logic                    push, pop;
   logic [SECTOR_BITS-1:0]  push_sector, head_sector;
   logic [W-1:0]            push_frac, push_sat, push_val;
   logic [W-1:0]            head_frac, head_sat, head_val;
   logic [DATA_BITS-1:0]    head_data;

   hsvrgb_front #(.COMPONENT_BITS(W)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .queue_status   (queue_status),
      .push           (push),
      .push_sector    (push_sector),
      .push_frac      (push_frac),
      .push_sat       (push_sat),
      .push_val       (push_val)
   );

   hsvrgb_queue #(.DATA_BITS(DATA_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_sector, push_frac, push_sat, push_val}),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   assign {head_sector, head_frac, head_sat, head_val} = head_data;

   hsvrgb_back #(.COMPONENT_BITS(W)) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop          (pop),
      .head_sector  (head_sector),
      .head_frac    (head_frac),
      .head_sat     (head_sat),
      .head_val     (head_val),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_red      (rsp_red),
      .rsp_green    (rsp_green),
      .rsp_blue     (rsp_blue)
   );

endmodule

`default_nettype wire

// File: rtl/core/hsvrgb_checker.sv
// Port-level checks for hsv_to_rgb_converter_core, attached by bind.
// Depends on hsvrgb_pkg and the top level's ports.
`default_nettype none

module hsvrgb_checker #(
   parameter int COMPONENT_BITS = hsvrgb_pkg::COMPONENT_BITS_DEFAULT
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [COMPONENT_BITS-1:0] rsp_red,
   input wire logic [COMPONENT_BITS-1:0] rsp_green,
   input wire logic [COMPONENT_BITS-1:0] rsp_blue
);

   logic [4:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 5'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 5'd0)
      else $error("result shown with no item outstanding");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 5'd0 |-> !req_stall)
      else $error("input stalled with nothing in flight");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
      else $error("rsp payload changed while stalled");

endmodule

bind hsv_to_rgb_converter_core hsvrgb_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_red   (rsp_red),
   .rsp_green (rsp_green),
   .rsp_blue  (rsp_blue)
);

`default_nettype wire

// File: tb/hsv_to_rgb_converter_core_tb.sv
// Self-checking bench for hsv_to_rgb_converter_core: HSV colors in, RGB checked against a
// fixed-point HSV-to-RGB predictor held in a small scoreboard class.
// Depends on hsvrgb_pkg and the converter RTL.
`timescale 1ns / 100ps

typedef struct packed {
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;
} rgb_color_type;

class hsv_color_checker;
   localparam int W = hsvrgb_pkg::COMPONENT_BITS_DEFAULT;
   localparam logic [63:0] FULL_SCALE = (64'd1 << W) - 64'd1;
   localparam logic [63:0] ONE_TURN = 64'd1 << W;

   rgb_color_type expected_colors[$];
   int unsigned failures;

   function rgb_color_type convert_hsv(logic [15:0] hue, logic [15:0] sat, logic [15:0] val);
      logic [63:0] h6, frac, s64, v64, kq, kt, p, q, t;
      logic [2:0] sector;
      rgb_color_type c;
      s64 = 64'(sat);
      v64 = 64'(val);
      h6 = 64'(hue) * 64'd6;
      sector = 3'(h6 >> W);
      frac = h6 & FULL_SCALE;
      kq = (frac * s64) >> W;
      kt = ((ONE_TURN - frac) * s64) >> W;
      p = (v64 * (FULL_SCALE - s64)) / FULL_SCALE;
      q = (v64 * (FULL_SCALE - kq)) / FULL_SCALE;
      t = (v64 * (FULL_SCALE - kt)) / FULL_SCALE;
      case (sector)
         hsvrgb_pkg::SECTOR_RED_YELLOW: begin
            c.red = v64[15:0]; c.green = t[15:0]; c.blue = p[15:0];
         end
         hsvrgb_pkg::SECTOR_YELLOW_GREEN: begin
            c.red = q[15:0]; c.green = v64[15:0]; c.blue = p[15:0];
         end
         hsvrgb_pkg::SECTOR_GREEN_CYAN: begin
            c.red = p[15:0]; c.green = v64[15:0]; c.blue = t[15:0];
         end
         hsvrgb_pkg::SECTOR_CYAN_BLUE: begin
            c.red = p[15:0]; c.green = q[15:0]; c.blue = v64[15:0];
         end
         hsvrgb_pkg::SECTOR_BLUE_MAGENTA: begin
            c.red = t[15:0]; c.green = p[15:0]; c.blue = v64[15:0];
         end
         default: begin
            c.red = v64[15:0]; c.green = p[15:0]; c.blue = q[15:0];
         end
      endcase
      return c;
   endfunction

   function void note_request(logic [15:0] hue, logic [15:0] sat, logic [15:0] val);
      expected_colors.push_back(convert_hsv(hue, sat, val));
   endfunction

   function void check_response(logic [15:0] red, logic [15:0] green, logic [15:0] blue);
      rgb_color_type exp_c;
      if (expected_colors.size() == 0) begin
         $error("unexpected rgb transfer: red %0d green %0d blue %0d", red, green, blue);
         failures++;
         return;
      end
      exp_c = expected_colors.pop_front();
      if (red !== exp_c.red) begin
         $error("red mismatch: expected %0d, got %0d", exp_c.red, red);
         failures++;
      end
      if (green !== exp_c.green) begin
         $error("green mismatch: expected %0d, got %0d", exp_c.green, green);
         failures++;
      end
      if (blue !== exp_c.blue) begin
         $error("blue mismatch: expected %0d, got %0d", exp_c.blue, blue);
         failures++;
      end
   endfunction

   function int pending();
      return expected_colors.size();
   endfunction
endclass

module hsv_to_rgb_converter_core_tb;

   localparam int RANDOM_COLORS = 1250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_hue = '0;
   logic [15:0] req_saturation = '0;
   logic [15:0] req_brightness = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_red;
   logic [15:0] rsp_green;
   logic [15:0] rsp_blue;

   bit quiet_phase = 1'b0;

   hsv_color_checker colors = new();

   hsv_to_rgb_converter_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic send_color(input logic [15:0] hue, input logic [15:0] sat,
                             input logic [15:0] val);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= val;
      do @(posedge clock); while (req_stall);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            colors.note_request(req_hue, req_saturation, req_brightness);
         if (rsp_valid && !rsp_stall)
            colors.check_response(rsp_red, rsp_green, rsp_blue);
      end
   end

   initial begin
      int stall_len;
      int run_len;
      @(negedge reset);
      forever begin
         stall_len = pick_gap();
         run_len = $urandom_range(1, 12);
         if (stall_len > 0) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (stall_len - 1) @(negedge clock);
            @(negedge clock) rsp_stall <= 1'b0;
         end
         repeat (run_len) @(negedge clock);
      end
   end

   initial begin
      logic [15:0] hue_edges [12];
      logic [15:0] hue, sat, val;
      int kind;
      hue_edges = '{16'd0, 16'd10922, 16'd10923, 16'd21845, 16'd21846,
                    16'd32767, 16'd32768, 16'd43690, 16'd43691,
                    16'd54613, 16'd54614, 16'd65535};
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // sector corners at full scale
      send_color(16'd0,     16'hFFFF, 16'hFFFF);
      send_color(16'd10922, 16'hFFFF, 16'hFFFF);
      send_color(16'd10923, 16'hFFFF, 16'hFFFF);
      send_color(16'd21845, 16'hFFFF, 16'hFFFF);
      send_color(16'd21846, 16'hFFFF, 16'hFFFF);
      send_color(16'd32768, 16'hFFFF, 16'hFFFF);
      send_color(16'd43690, 16'hFFFF, 16'hFFFF);
      send_color(16'd43691, 16'hFFFF, 16'hFFFF);
      send_color(16'd54613, 16'hFFFF, 16'hFFFF);
      send_color(16'd54614, 16'hFFFF, 16'hFFFF);
      send_color(16'd65535, 16'hFFFF, 16'hFFFF);
      // grey when saturation is zero
      send_color(16'd5000,  16'd0,    16'd40000);
      send_color(16'd65535, 16'd0,    16'hFFFF);
      // black when brightness is zero, then near-extreme and alternating-bit colors
      send_color(16'd30000, 16'hFFFF, 16'd0);
      send_color(16'd65535, 16'd12345, 16'd0);
      send_color(16'd0,     16'd0,    16'd0);
      send_color(16'hFFFF,  16'd1,    16'd1);
      send_color(16'd1,     16'hFFFE, 16'hFFFE);
      send_color(16'hAAAA,  16'h5555, 16'hAAAA);
      send_color(16'h5555,  16'hAAAA, 16'h5555);

      for (int i = 0; i < RANDOM_COLORS; i++) begin
         quiet_phase = ((i / 125) % 4) == 1;
         hue = 16'($urandom);
         sat = 16'($urandom);
         val = 16'($urandom);
         kind = $urandom_range(0, 9);
         case (kind)
            0: sat = 16'd0;
            1: val = 16'd0;
            2: begin
               sat = 16'hFFFF;
               val = 16'hFFFF;
            end
            3: hue = hue_edges[$urandom_range(0, 11)];
            default: ;
         endcase
         send_color(hue, sat, val);
      end
      quiet_phase = 1'b0;

      @(negedge clock) req_valid <= 1'b0;
      while (colors.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (colors.failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: files.f
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_front.sv
rtl/core/hsvrgb_queue.sv
rtl/core/hsvrgb_back.sv
rtl/core/hsv_to_rgb_converter_core.sv
rtl/core/hsvrgb_checker.sv
tb/hsv_to_rgb_converter_core_tb.sv
